// ===== src/hbpa_pkg.sv =====
// Shared types, constants and helper functions of the hierarchical bitmap page allocator.
package hbpa_pkg;

	localparam int unsigned MAX_PAGES  = 4096;
	localparam int unsigned WORD_BITS  = 32;
	localparam int unsigned LEAF_WORDS = MAX_PAGES / WORD_BITS;
	localparam int unsigned MID_WORDS  = LEAF_WORDS / WORD_BITS;
	localparam int unsigned LEAF_AW    = $clog2(LEAF_WORDS);
	localparam int unsigned MID_AW     = $clog2(MID_WORDS);
	localparam int unsigned PAGE_W     = 12;
	localparam int unsigned COUNT_W    = 13;

	localparam logic [COUNT_W-1:0]   PAGE_LIMIT  = COUNT_W'(MAX_PAGES);
	localparam logic [WORD_BITS-1:0] FULL_WORD   = '1;
	localparam logic [MID_WORDS-1:0] ROOT_FULL   = '1;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_REBUILD = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_SWEEP,
		S_FIN,
		S_DONE
	} hbpa_state_t;

	// One write request into the leaf store.
	typedef struct packed {
		logic                 en;
		logic [LEAF_AW-1:0]   addr;
		logic [WORD_BITS-1:0] data;
	} leaf_wr_t;

	// Position of the lowest zero bit; bit 5 set means the word is full.
	function automatic logic [5:0] lowest_zero32(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] iso;
		logic [5:0]           pos;
		iso = ~w & (w + 32'd1);
		pos = 6'd0;
		if (iso == '0) begin
			pos = 6'd32;
		end else begin
			for (int i = 0; i < WORD_BITS; i++) begin
				if (iso[i]) begin
					pos = pos | 6'(i);
				end
			end
		end
		return pos;
	endfunction

	// Lowest zero of the root word; its result is used only when the root is not full.
	function automatic logic [MID_AW-1:0] lowest_zero_root(input logic [MID_WORDS-1:0] w);
		logic [MID_WORDS-1:0] iso;
		logic [MID_AW-1:0]    pos;
		iso = ~w & (w + MID_WORDS'(1));
		pos = '0;
		for (int i = 0; i < MID_WORDS; i++) begin
			if (iso[i]) begin
				pos = pos | MID_AW'(i);
			end
		end
		return pos;
	endfunction

	// Leaf word contents right after a rebuild: pages at or above limit are used.
	function automatic logic [WORD_BITS-1:0] rebuild_word(input logic [LEAF_AW-1:0] l,
		input logic [COUNT_W-1:0] limit);
		logic [COUNT_W-6:0]   lw;
		logic [WORD_BITS-1:0] w;
		lw = limit[COUNT_W-1:5];
		if ((COUNT_W-5)'(l) < lw) begin
			w = '0;
		end else if ((COUNT_W-5)'(l) == lw) begin
			w = FULL_WORD << limit[4:0];
		end else begin
			w = FULL_WORD;
		end
		return w;
	endfunction

endpackage

// ===== src/hbpa_leaf_mem.sv =====
// Leaf word store: one synchronous write port and one registered read port.
module hbpa_leaf_mem
	import hbpa_pkg::*;
(
	input  logic                 clk,
	input  leaf_wr_t             wr,
	input  logic                 rd_en,
	input  logic [LEAF_AW-1:0]   rd_addr,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem [LEAF_WORDS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/hierarchical_bitmap_page_allocator.sv =====
// Top level of the hierarchical bitmap page allocator.
//
//  channel | signals                                  | dir | request content
//  --------+------------------------------------------+-----+---------------------------
//  req     | req_valid, req_stall, opcode, free_index | in  | allocate, free or rebuild
//  rsp     | rsp_valid, rsp_stall, page_index, status | out | one result per request
//  cfg     | cfg_valid, cfg_ready, page_count         | in  | usable page count
//
// An allocate or free is accepted, then reads the leaf store, then modifies and writes back
// the three tree levels, then loads the response register before the next acceptance.
// Range errors, unknown opcodes and allocations that find the upper levels full skip the leaf steps.
// A rebuild sweeps the 128 leaf words one per cycle and then refreshes the root.
// After reset the same sweep clears the leaf store before the first request is taken;
// configuration writes are accepted throughout.
// A stalled response holds the block in its final state until the response is taken.
module hierarchical_bitmap_page_allocator
	import hbpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         opcode,
	input  logic [PAGE_W-1:0]  free_index,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [PAGE_W-1:0]  page_index,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] page_count
);

	hbpa_state_t state_q, state_d;

	// Configuration and the limit that the running sweep uses.
	logic [COUNT_W-1:0] page_count_q;
	logic [COUNT_W-1:0] limit_q;
	logic [COUNT_W-1:0] usable;

	// Upper tree levels live in flops; the leaf level lives in the memory.
	logic [WORD_BITS-1:0] middle_q [MID_WORDS];
	logic [MID_WORDS-1:0] root_q;
	logic [MID_WORDS-1:0] root_calc;

	// Request context kept while the leaf read is in flight.
	op_t                op_q;
	logic [LEAF_AW-1:0] la_q;
	logic [4:0]         bit_q;
	logic [LEAF_AW-1:0] cnt_q;
	logic               sweep_rsp_q;

	// Result waiting for the response register.
	logic [PAGE_W-1:0] res_page_q;
	status_t           res_status_q;
	logic              rsp_valid_q;
	logic [PAGE_W-1:0] page_index_q;
	status_t           status_q;

	// Combinational controls.
	leaf_wr_t             leaf_wr;
	logic                 rd_en;
	logic [LEAF_AW-1:0]   rd_addr;
	logic [WORD_BITS-1:0] rd_data;
	logic                 req_fire;
	op_t                  req_op;
	logic                 ld_ctx;
	logic [LEAF_AW-1:0]   la_d;
	logic                 ld_res;
	logic [PAGE_W-1:0]    res_page_d;
	status_t              res_status_d;
	logic                 start_sweep;
	logic                 mid_we;
	logic [LEAF_AW-1:0]   mid_pos;
	logic                 mid_val;
	logic                 root_we;
	logic                 root_val;
	logic                 root_load;
	logic                 rsp_load;
	logic                 rsp_free;

	logic [MID_AW-1:0]    root_pick;
	logic [5:0]           mid_zero;
	logic [5:0]           leaf_zero;
	logic [WORD_BITS-1:0] leaf_new;
	logic [WORD_BITS-1:0] mid_new;
	logic [WORD_BITS-1:0] sweep_word;

	assign usable    = (page_count_q > PAGE_LIMIT) ? PAGE_LIMIT : page_count_q;
	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign req_op    = op_t'(opcode);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign root_pick  = lowest_zero_root(root_q);
	assign mid_zero   = lowest_zero32(middle_q[root_pick]);
	assign leaf_zero  = lowest_zero32(rd_data);
	assign sweep_word = rebuild_word(cnt_q, limit_q);

	always_comb begin
		for (int i = 0; i < MID_WORDS; i++) begin
			root_calc[i] = (middle_q[i] == FULL_WORD);
		end
	end

	// The middle word touched by the modify step, with its new fullness bit in place.
	always_comb begin
		mid_new = middle_q[mid_pos[LEAF_AW-1:5]];
		mid_new[mid_pos[4:0]] = mid_val;
	end

	hbpa_leaf_mem u_leaf_mem (
		.clk     (clk),
		.wr      (leaf_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Next state and control.
	always_comb begin
		state_d      = state_q;
		leaf_wr      = '0;
		rd_en        = 1'b0;
		rd_addr      = '0;
		ld_ctx       = 1'b0;
		la_d         = '0;
		ld_res       = 1'b0;
		res_page_d   = '0;
		res_status_d = ST_OK;
		start_sweep  = 1'b0;
		mid_we       = 1'b0;
		mid_pos      = la_q;
		mid_val      = 1'b0;
		root_we      = 1'b0;
		root_val     = 1'b0;
		root_load    = 1'b0;
		rsp_load     = 1'b0;
		leaf_new     = rd_data;

		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					unique case (req_op)
						OP_ALLOC: begin
							// Walk the two upper levels now and fetch the leaf word.
							if (root_q == ROOT_FULL || mid_zero[5]) begin
								ld_res       = 1'b1;
								res_status_d = ST_NO_FREE;
								state_d      = S_DONE;
							end else begin
								la_d    = {root_pick, mid_zero[4:0]};
								ld_ctx  = 1'b1;
								rd_en   = 1'b1;
								rd_addr = la_d;
								state_d = S_MOD;
							end
						end
						OP_FREE: begin
							if ({1'b0, free_index} >= usable) begin
								ld_res       = 1'b1;
								res_status_d = ST_RANGE;
								state_d      = S_DONE;
							end else begin
								la_d    = free_index[PAGE_W-1:5];
								ld_ctx  = 1'b1;
								rd_en   = 1'b1;
								rd_addr = la_d;
								state_d = S_MOD;
							end
						end
						OP_REBUILD: begin
							start_sweep = 1'b1;
							state_d     = S_SWEEP;
						end
						OP_NONE: begin
							ld_res  = 1'b1;
							state_d = S_DONE;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_MOD: begin
				ld_res  = 1'b1;
				state_d = S_DONE;
				if (op_q == OP_ALLOC) begin
					if (leaf_zero[5]) begin
						res_status_d = ST_NO_FREE;
					end else begin
						leaf_new   = rd_data | (WORD_BITS'(1) << leaf_zero[4:0]);
						res_page_d = {la_q, leaf_zero[4:0]};
						leaf_wr    = '{en: 1'b1, addr: la_q, data: leaf_new};
					end
				end else begin
					leaf_new = rd_data & ~(WORD_BITS'(1) << bit_q);
					leaf_wr  = '{en: 1'b1, addr: la_q, data: leaf_new};
				end
				mid_we   = leaf_wr.en;
				mid_val  = (leaf_new == FULL_WORD);
				root_we  = leaf_wr.en;
				root_val = (mid_new == FULL_WORD);
			end
			S_SWEEP: begin
				leaf_wr = '{en: 1'b1, addr: cnt_q, data: sweep_word};
				mid_we  = 1'b1;
				mid_pos = cnt_q;
				mid_val = (sweep_word == FULL_WORD);
				if (cnt_q == LEAF_AW'(LEAF_WORDS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				root_load = 1'b1;
				ld_res    = sweep_rsp_q;
				state_d   = sweep_rsp_q ? S_DONE : S_IDLE;
			end
			S_DONE: begin
				if (rsp_free) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: configuration, sweep bookkeeping, root and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= PAGE_LIMIT;
			limit_q      <= PAGE_LIMIT;
			cnt_q        <= '0;
			sweep_rsp_q  <= 1'b0;
			root_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				page_count_q <= page_count;
			end
			if (start_sweep) begin
				limit_q     <= usable;
				cnt_q       <= '0;
				sweep_rsp_q <= 1'b1;
			end else if (state_q == S_SWEEP) begin
				cnt_q <= cnt_q + LEAF_AW'(1);
			end
			if (root_load) begin
				root_q <= root_calc;
			end else if (root_we) begin
				root_q[mid_pos[LEAF_AW-1:5]] <= root_val;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (mid_we) begin
			middle_q[mid_pos[LEAF_AW-1:5]][mid_pos[4:0]] <= mid_val;
		end
		if (ld_ctx) begin
			op_q  <= req_op;
			la_q  <= la_d;
			bit_q <= free_index[4:0];
		end
		if (ld_res) begin
			res_page_q   <= res_page_d;
			res_status_q <= res_status_d;
		end
		if (rsp_load) begin
			page_index_q <= res_page_q;
			status_q     <= res_status_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign page_index = page_index_q;
	assign status     = status_q;

	// Between requests every root bit agrees with the fullness of its middle word.
	a_root_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (root_q == root_calc))
		else $error("root word disagrees with middle words");

	// The leaf store is written only by a modify step or by the sweep.
	a_leaf_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		leaf_wr.en |-> (state_q == S_MOD || state_q == S_SWEEP))
		else $error("leaf write outside modify or sweep");

	// The sweep ends after the last leaf word and then refreshes the root.
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && cnt_q == LEAF_AW'(LEAF_WORDS - 1)) |=> (state_q == S_FIN))
		else $error("sweep did not finish at the last leaf word");

endmodule
